/* hdl/tccw_pkg.sv */
// Shared constants, types and the control store of the text console cell writer.
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PH_W   = $clog2(TAB_WIDTH);

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    // Stream payload sizes
    localparam int IN_BITS  = 16 + ROW_W + COL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = COL_W + ROW_W + ADDR_W + 1 + 16;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_RD_CELL,
        MEM_COPY,
        MEM_BLANK
    } mem_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_LAST_ROW
    } ptr_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_PUT
    } cur_op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_NO_SCROLL,
        COND_COPY_MORE,
        COND_BLANK_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_RST0  = 4'd0;
    localparam step_t ST_RST1  = 4'd1;
    localparam step_t ST_RST2  = 4'd2;
    localparam step_t ST_PUT0  = 4'd3;
    localparam step_t ST_PUT1  = 4'd4;
    localparam step_t ST_COPY  = 4'd5;
    localparam step_t ST_DRAIN = 4'd6;
    localparam step_t ST_BLANK = 4'd7;
    localparam step_t ST_EMIT  = 4'd8;
    localparam step_t ST_WAIT  = 4'd9;
    localparam step_t ST_CLR0  = 4'd10;
    localparam step_t ST_READ0 = 4'd11;

    typedef struct packed {
        mem_op_t mem_op;
        ptr_op_t ptr_op;
        cur_op_t cur_op;
        cond_t   cond;
        step_t   target;
        logic    accept;
        logic    emit;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        cmd_t cmd;
        logic out_busy;
        logic scroll;
        logic copy_more;
        logic blank_more;
    } seq_flags_t;

    // Control store: one word per step
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{mem_op: MEM_NONE, ptr_op: PTR_HOLD, cur_op: CUR_HOLD,
               cond: COND_ALWAYS, target: ST_WAIT, accept: 1'b0, emit: 1'b0};
        unique case (step)
            ST_RST0: begin
                cw.ptr_op = PTR_ZERO;
                cw.cond   = COND_NEXT;
            end
            ST_RST1: begin
                cw.mem_op = MEM_BLANK;
                cw.ptr_op = PTR_INC;
                cw.cond   = COND_BLANK_MORE;
                cw.target = ST_RST1;
            end
            ST_RST2: begin
                cw.target = ST_WAIT;
            end
            ST_PUT0: begin
                cw.mem_op = MEM_PUT;
                cw.cur_op = CUR_PUT;
                cw.ptr_op = PTR_ZERO;
                cw.cond   = COND_NEXT;
            end
            ST_PUT1: begin
                cw.cond   = COND_NO_SCROLL;
                cw.target = ST_EMIT;
            end
            ST_COPY: begin
                cw.mem_op = MEM_COPY;
                cw.ptr_op = PTR_INC;
                cw.cond   = COND_COPY_MORE;
                cw.target = ST_COPY;
            end
            ST_DRAIN: begin
                cw.ptr_op = PTR_LAST_ROW;
                cw.cond   = COND_NEXT;
            end
            ST_BLANK: begin
                cw.mem_op = MEM_BLANK;
                cw.ptr_op = PTR_INC;
                cw.cond   = COND_BLANK_MORE;
                cw.target = ST_BLANK;
            end
            ST_EMIT: begin
                cw.emit   = 1'b1;
                cw.cond   = COND_OUT_BUSY;
                cw.target = ST_EMIT;
            end
            ST_WAIT: begin
                cw.accept = 1'b1;
                cw.cond   = COND_DISPATCH;
                cw.target = ST_WAIT;
            end
            ST_CLR0: begin
                cw.cur_op = CUR_HOME;
                cw.ptr_op = PTR_ZERO;
                cw.target = ST_BLANK;
            end
            ST_READ0: begin
                cw.mem_op = MEM_RD_CELL;
                cw.target = ST_EMIT;
            end
            default: begin
                cw.target = ST_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* hdl/tccw_seq.sv */
// Step counter and control store of the text console cell writer.
`default_nettype none

module tccw_seq
    import tccw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire seq_flags_t flags,
    output ctrl_t           ctrl
);

    step_t step_reg;
    step_t step_next;
    step_t dispatch;
    logic  taken;

    assign ctrl = ucode(step_reg);

    always_comb begin
        unique case (flags.cmd)
            CMD_PUT:   dispatch = ST_PUT0;
            CMD_CLEAR: dispatch = ST_CLR0;
            CMD_READ:  dispatch = ST_READ0;
            CMD_NONE:  dispatch = ST_EMIT;
            default:   dispatch = ST_EMIT;
        endcase
    end

    always_comb begin
        unique case (ctrl.cond)
            COND_NEXT:       taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_DISPATCH:   taken = !flags.in_fire;
            COND_NO_SCROLL:  taken = !flags.scroll;
            COND_COPY_MORE:  taken = flags.copy_more;
            COND_BLANK_MORE: taken = flags.blank_more;
            COND_OUT_BUSY:   taken = flags.out_busy;
            default:         taken = 1'b0;
        endcase

        // Dispatch jumps by command; otherwise branch or advance
        if (ctrl.cond == COND_DISPATCH && flags.in_fire) begin
            step_next = dispatch;
        end else if (taken) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_t'(step_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_RST0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/text_console_cell_writer.sv */
// Top level of the text console cell writer: cell store, cursor datapath and stream ports.
`default_nettype none

// Text console over an 80x25 store of 16-bit cells (attribute byte high, character
// low), driven by a small microcoded sequencer. One request is taken at a time and
// yields exactly one result. A put that scrolls adds one memory sweep: copying each
// line up (one cell per cycle through the single-write, single-read cell store), a
// drain step and blanking the bottom line. A clear blanks the whole store. After
// reset the block runs a clearing pass over the store with s_tready low. A finished
// result waits in the output register while the next request is accepted, so output
// stalls only hold the block once a second result is ready.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // char_code[7:0], background[11:8], foreground[15:12], read_row, read_col, zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]       s_tuser,

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // cursor_col, cursor_row, cursor_location, scrolled, cell_value[15:0], zero pad
    output logic [OUT_W-1:0]      m_tdata
);

    // Wide enough for a column plus one tab step
    localparam int CX_W = COL_W + 2;

    ctrl_t      ctrl;
    seq_flags_t flags;
    logic       in_fire;
    logic       out_busy;
    logic       out_load;

    // Request fields
    logic [7:0]       s_char;
    logic [3:0]       s_back;
    logic [3:0]       s_fore;
    logic [ROW_W-1:0] s_row;
    logic [COL_W-1:0] s_col;
    logic             s_rd_ok;

    // Latched request
    cmd_t              cmd_reg;
    logic [7:0]        char_reg;
    logic [3:0]        back_reg;
    logic [3:0]        fore_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_ok_reg;

    // Cursor state
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic              scroll_reg, scroll_next;
    logic [ADDR_W-1:0] cur_addr;

    // Put results
    logic [CX_W-1:0]   pc_col;
    logic [ROW_W:0]    pc_row;
    logic [PH_W-1:0]   pc_ph;
    logic              pc_print;
    logic              pc_scroll;

    // Sweep pointer and delayed copy write
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [ADDR_W-1:0] cp_addr_reg;

    // Cell store ports
    logic [15:0]       cells_mem [CELLS];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data_reg;

    // Output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  mdata_reg, mdata_next;
    logic [15:0]       cell_value;

    // ---------------------------------------------------------------- sequencer
    tccw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign s_tready = ctrl.accept;
    assign in_fire  = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = ctrl.emit && !out_busy;

    always_comb begin
        flags.in_fire    = in_fire;
        flags.cmd        = cmd_t'(s_tuser);
        flags.out_busy   = out_busy;
        flags.scroll     = scroll_reg;
        flags.copy_more  = (ptr_reg != ADDR_W'(CELLS - COLUMNS - 1));
        flags.blank_more = (ptr_reg != ADDR_W'(CELLS - 1));
    end

    // ---------------------------------------------------------------- request capture
    assign s_char = s_tdata[7:0];
    assign s_back = s_tdata[11:8];
    assign s_fore = s_tdata[15:12];
    assign s_row  = s_tdata[16 +: ROW_W];
    assign s_col  = s_tdata[16 + ROW_W +: COL_W];

    // Reads outside the screen return zero and touch nothing
    assign s_rd_ok = ({1'b0, s_row} < (ROW_W + 1)'(ROWS))
                  && ({1'b0, s_col} < (COL_W + 1)'(COLUMNS));

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg     <= cmd_t'(s_tuser);
            char_reg    <= s_char;
            back_reg    <= s_back;
            fore_reg    <= s_fore;
            rd_addr_reg <= ADDR_W'(ADDR_W'(s_row) * ADDR_W'(COLUMNS)) + ADDR_W'(s_col);
            rd_ok_reg   <= s_rd_ok;
        end
    end

    // ---------------------------------------------------------------- cursor datapath
    assign cur_addr = ADDR_W'(ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col_reg);

    // phase_reg tracks the column modulo the tab width, so a tab needs no divide
    always_comb begin
        pc_col    = CX_W'(cur_col_reg);
        pc_row    = {1'b0, cur_row_reg};
        pc_ph     = phase_reg;
        pc_print  = !char_reg[7] && (char_reg[6:5] != 2'b00);
        pc_scroll = 1'b0;

        case (char_reg)
            CH_BS: begin
                if (cur_col_reg != '0) begin
                    pc_col = pc_col - 1'b1;
                    pc_ph  = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1) : phase_reg - 1'b1;
                end
            end
            CH_TAB: begin
                pc_col = pc_col + CX_W'(TAB_WIDTH) - CX_W'(phase_reg);
                pc_ph  = '0;
            end
            CH_CR: begin
                pc_col = '0;
                pc_ph  = '0;
            end
            CH_LF: begin
                pc_col = '0;
                pc_row = pc_row + 1'b1;
                pc_ph  = '0;
            end
            default: begin
                if (pc_print) begin
                    pc_col = pc_col + 1'b1;
                    pc_ph  = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_reg + 1'b1;
                end
            end
        endcase

        // Wrap at the end of the line
        if (pc_col >= CX_W'(COLUMNS)) begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
            pc_ph  = '0;
        end

        // Past the last row: hold on the bottom row and scroll the store
        if (pc_row >= (ROW_W + 1)'(ROWS)) begin
            pc_row    = (ROW_W + 1)'(ROWS - 1);
            pc_scroll = 1'b1;
        end
    end

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        phase_next   = phase_reg;
        scroll_next  = scroll_reg;

        if (in_fire) begin
            scroll_next = 1'b0;
        end

        case (ctrl.cur_op)
            CUR_HOME: begin
                cur_col_next = '0;
                cur_row_next = '0;
                phase_next   = '0;
            end
            CUR_PUT: begin
                cur_col_next = pc_col[COL_W-1:0];
                cur_row_next = pc_row[ROW_W-1:0];
                phase_next   = pc_ph;
                scroll_next  = pc_scroll;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- sweep pointer
    always_comb begin
        case (ctrl.ptr_op)
            PTR_ZERO:     ptr_next = '0;
            PTR_INC:      ptr_next = ptr_reg + 1'b1;
            PTR_LAST_ROW: ptr_next = ADDR_W'(CELLS - COLUMNS);
            default:      ptr_next = ptr_reg;
        endcase
    end

    // Copy reads one line ahead; the write lands in the next cycle at the pointer
    assign cp_pend_next = (ctrl.mem_op == MEM_COPY);

    // ---------------------------------------------------------------- cell store
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {back_reg, fore_reg, char_reg};
        rd_en   = 1'b0;
        rd_addr = ptr_reg + ADDR_W'(COLUMNS);

        if (cp_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = cp_addr_reg;
            wr_data = rd_data_reg;
        end

        case (ctrl.mem_op)
            MEM_PUT: begin
                wr_en = pc_print;
            end
            MEM_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = BLANK_CELL;
            end
            MEM_COPY: begin
                rd_en = 1'b1;
            end
            MEM_RD_CELL: begin
                rd_en   = rd_ok_reg;
                rd_addr = rd_addr_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cells_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- result register
    assign cell_value = (cmd_reg == CMD_READ && rd_ok_reg) ? rd_data_reg : 16'h0000;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        mdata_next    = mdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            mdata_next    = '0;
            mdata_next[OUT_BITS-1:0] = {cell_value, scroll_reg, cur_addr,
                                        cur_row_reg, cur_col_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mdata_reg;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            phase_reg    <= '0;
            scroll_reg   <= 1'b0;
            ptr_reg      <= '0;
            cp_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            phase_reg    <= phase_next;
            scroll_reg   <= scroll_next;
            ptr_reg      <= ptr_next;
            cp_pend_reg  <= cp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= ptr_reg;
        mdata_reg   <= mdata_next;
    end

    // ---------------------------------------------------------------- assertions
    // The cursor never leaves the screen
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_col_reg} < (COL_W + 1)'(COLUMNS))
        && ({1'b0, cur_row_reg} < (ROW_W + 1)'(ROWS)))
        else $error("cursor left the screen");

    // A delayed copy write never meets another write to the store
    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_pend_reg |-> !(ctrl.mem_op == MEM_BLANK || ctrl.mem_op == MEM_PUT))
        else $error("copy write collides with another store write");

    // One request at a time: ready drops right after an acceptance
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("request accepted while the previous one is in work");

endmodule

`default_nettype wire
